FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Every macro samples on the rising edge of clk and is off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property: label, property body, message.
`define GMC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication with the consequent in the next cycle: label, cause, effect, message.
`define GMC_ASSERT_NEXT(label, cause, effect, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cause) |=> (effect)) \
		else $error(msg);

`endif

FILE: design/gmc_pkg.sv
// ---------------------------------------------------------------------------
// gmc_pkg
// Types and constants of the gate motion controller: payload structs,
// state codes, register indexes and reset values.
// ---------------------------------------------------------------------------
package gmc_pkg;

	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OBSTACLE_THRESHOLD = 8'd0,
		CFG_OPEN_TIMEOUT       = 8'd1,
		CFG_CLOSE_TIMEOUT      = 8'd2,
		CFG_UNLOCK_CODE        = 8'd3
	} cfg_reg_t;

	localparam logic [9:0]  THRESHOLD_RST    = 10'd10;
	localparam logic [15:0] OPEN_TIMEOUT_RST = 16'd1200;
	localparam logic [15:0] CLOSE_TIMEOUT_RST = 16'd3600;
	localparam logic [31:0] UNLOCK_CODE_RST  = 32'h3132_3334; // "1234"

	typedef enum logic [2:0] {
		ST_INIT    = 3'd0,
		ST_OPENING = 3'd1,
		ST_CLOSING = 3'd2,
		ST_CLOSED  = 3'd3,
		ST_OPEN    = 3'd4,
		ST_EMERG   = 3'd5,
		ST_ERROR   = 3'd6,
		ST_WAIT    = 3'd7
	} gate_state_t;

	typedef struct packed {
		logic       limit_open;
		logic       limit_closed;
		logic       cmd_open;
		logic       cmd_close;
		logic [9:0] distance;
		logic       key_valid;
		logic [7:0] key_code;
	} in_t;

	typedef struct packed {
		logic       motor_open;
		logic       motor_close;
		logic       led_moving;
		logic       led_alarm;
		logic       led_fault;
		logic [2:0] state_code;
	} out_t;

	typedef struct packed {
		logic [9:0]  obstacle_threshold;
		logic [15:0] open_timeout;
		logic [15:0] close_timeout;
		logic [31:0] unlock_code;
	} cfg_t;

	// Controller state apart from the key counter, whose width follows CODE_KEYS.
	typedef struct packed {
		gate_state_t state;
		gate_state_t resume;
		logic [15:0] motion_ticks;
		logic [31:0] entered_code;
		logic        alarm_blink;
		logic        fault_blink;
	} ctl_t;

endpackage

FILE: design/gmc_cfg.sv
// ---------------------------------------------------------------------------
// gmc_cfg
// Configuration register file: threshold, timeouts and unlock code.
// Writes to an index outside the register list are dropped.
// ---------------------------------------------------------------------------
module gmc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gmc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gmc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output gmc_pkg::cfg_t                   cfg
);
	import gmc_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.obstacle_threshold <= THRESHOLD_RST;
			cfg_q.open_timeout       <= OPEN_TIMEOUT_RST;
			cfg_q.close_timeout      <= CLOSE_TIMEOUT_RST;
			cfg_q.unlock_code        <= UNLOCK_CODE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_OBSTACLE_THRESHOLD: cfg_q.obstacle_threshold <= cfg_data[9:0];
				CFG_OPEN_TIMEOUT:       cfg_q.open_timeout       <= cfg_data[15:0];
				CFG_CLOSE_TIMEOUT:      cfg_q.close_timeout      <= cfg_data[15:0];
				CFG_UNLOCK_CODE:        cfg_q.unlock_code        <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: design/gmc_next.sv
// ---------------------------------------------------------------------------
// gmc_next
// Next-state and result logic for one tick: obstacle compare, transition
// priorities, timeouts, key entry and the output decode of the new state.
// ---------------------------------------------------------------------------
module gmc_next #(
	parameter int CODE_KEYS = 4,
	localparam int KeyCntW = (CODE_KEYS > 1) ? $clog2(CODE_KEYS) : 1
) (
	input  gmc_pkg::in_t         item,
	input  gmc_pkg::cfg_t        cfg,
	input  gmc_pkg::ctl_t        cur,
	input  logic [KeyCntW-1:0]   keys,
	output gmc_pkg::ctl_t        nxt,
	output logic [KeyCntW-1:0]   keys_next,
	output gmc_pkg::out_t        result
);
	import gmc_pkg::*;

	localparam logic [KeyCntW-1:0] KeyLast = KeyCntW'(CODE_KEYS - 1);

	logic        obst;
	logic        key_ok;
	logic [31:0] shifted;
	gate_state_t target;
	logic        alarm_t;
	logic        fault_t;
	logic [31:0] code_t;
	logic [KeyCntW-1:0] keys_t;
	logic        moving;

	assign obst    = item.distance < cfg.obstacle_threshold;
	assign key_ok  = item.key_valid && (item.key_code != 8'd0);
	assign shifted = {cur.entered_code[23:0], item.key_code};

	always_comb begin
		target  = cur.state;
		alarm_t = cur.alarm_blink;
		fault_t = cur.fault_blink;
		code_t  = cur.entered_code;
		keys_t  = keys;
		unique case (cur.state)
			ST_INIT, ST_CLOSED, ST_OPEN: target = ST_WAIT;
			ST_WAIT: begin
				if (!item.limit_open && !obst && !item.limit_closed)
					target = ST_CLOSING;
				else if (item.cmd_open && !obst && !item.limit_open)
					target = ST_OPENING;
				else if (item.cmd_close && !obst && !item.limit_closed)
					target = ST_CLOSING;
				else if (obst)
					target = ST_EMERG;
				else if (item.limit_open && item.limit_closed)
					target = ST_ERROR;
			end
			ST_OPENING: begin
				if (item.limit_open)                         target = ST_OPEN;
				else if (obst)                               target = ST_EMERG;
				else if (item.cmd_close)                     target = ST_CLOSING;
				else if (cur.motion_ticks == cfg.open_timeout) target = ST_ERROR;
			end
			ST_CLOSING: begin
				if (item.limit_closed)                        target = ST_CLOSED;
				else if (obst)                                target = ST_EMERG;
				else if (item.cmd_open)                       target = ST_OPENING;
				else if (cur.motion_ticks == cfg.close_timeout) target = ST_ERROR;
			end
			ST_EMERG: begin
				if (!obst) target = cur.resume;
				else       alarm_t = ~cur.alarm_blink;
			end
			ST_ERROR: begin
				fault_t = ~cur.fault_blink;
				if (key_ok) begin
					if (keys >= KeyLast) begin
						if (shifted == cfg.unlock_code) begin
							target = ST_WAIT;
							code_t = shifted;
						end else begin
							// wrong code: start the entry over
							code_t = '0;
							keys_t = '0;
						end
					end else begin
						code_t = shifted;
						keys_t = keys + 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	assign moving = (target == ST_OPENING) || (target == ST_CLOSING);

	always_comb begin
		nxt.state        = target;
		nxt.resume       = cur.resume;
		nxt.motion_ticks = moving ? cur.motion_ticks + 16'd1 : 16'd0;
		nxt.alarm_blink  = alarm_t;
		nxt.fault_blink  = fault_t;
		nxt.entered_code = code_t;
		keys_next        = keys_t;
		if (target != cur.state) begin
			nxt.resume = cur.state;
			if (target == ST_EMERG)
				nxt.alarm_blink = 1'b1;
			if (target == ST_ERROR) begin
				nxt.fault_blink  = 1'b1;
				nxt.entered_code = '0;
				keys_next        = '0;
			end
		end
	end

	assign result.motor_open  = (target == ST_OPENING);
	assign result.motor_close = (target == ST_CLOSING);
	assign result.led_moving  = moving;
	assign result.led_alarm   = (target == ST_EMERG) && nxt.alarm_blink;
	assign result.led_fault   = (target == ST_ERROR) && nxt.fault_blink;
	assign result.state_code  = 3'(target);

endmodule

FILE: design/gate_motion_controller.sv
// ---------------------------------------------------------------------------
// gate_motion_controller
// Tick-driven controller for a motorized gate with obstacle stop, travel
// timeouts and keypad unlock from the error state.
// ---------------------------------------------------------------------------
// Each input transfer is one tick of sensor samples and yields exactly one
// result transfer describing the gate after that tick. The block takes one
// tick per clock while the output is not stalled: a tick is held in the input
// register while its next state and result are computed, and moves into the
// result register when that register is free or being emptied.
// The state registers update as the result register loads, which sets the
// one-tick-per-clock throughput. Both registers hold while the output is
// stalled. Configuration writes are always accepted, take effect at the edge
// that accepts them, and belong between ticks, with the block idle.
module gate_motion_controller #(
	parameter int CODE_KEYS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  gmc_pkg::in_t                    in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output gmc_pkg::out_t                   out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gmc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gmc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import gmc_pkg::*;

`include "assert_macros.svh"

	localparam int KeyCntW = (CODE_KEYS > 1) ? $clog2(CODE_KEYS) : 1;

	cfg_t               cfg;
	logic               in_valid_s1;
	in_t                in_s1;
	logic               out_valid_s2;
	out_t               res_s2;
	ctl_t               ctl_q;
	logic [KeyCntW-1:0] keys_q;
	ctl_t               ctl_next;
	logic [KeyCntW-1:0] keys_next;
	out_t               result;
	logic               advance;

	gmc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	gmc_next #(
		.CODE_KEYS(CODE_KEYS)
	) u_next (
		.item     (in_s1),
		.cfg      (cfg),
		.cur      (ctl_q),
		.keys     (keys_q),
		.nxt      (ctl_next),
		.keys_next(keys_next),
		.result   (result)
	);

	// Advance a tick when the result register is free or being emptied.
	assign advance  = in_valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready = !in_valid_s1 || advance;

	assign out_valid = out_valid_s2;
	assign out_data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.state        <= ST_INIT;
			ctl_q.resume       <= ST_INIT;
			ctl_q.motion_ticks <= '0;
			ctl_q.entered_code <= '0;
			ctl_q.alarm_blink  <= 1'b0;
			ctl_q.fault_blink  <= 1'b0;
			keys_q             <= '0;
		end else if (advance) begin
			ctl_q  <= ctl_next;
			keys_q <= keys_next;
		end
	end

	`GMC_ASSERT(a_ticks_idle,
		(ctl_q.state == ST_OPENING || ctl_q.state == ST_CLOSING) ||
		ctl_q.motion_ticks == 16'd0, "motion ticks nonzero while gate not moving")
	`GMC_ASSERT(a_keys_range, keys_q <= KeyCntW'(CODE_KEYS - 1),
		"key counter beyond the code length")
	`GMC_ASSERT(a_motor_excl, !(out_valid && out_data.motor_open && out_data.motor_close),
		"motor driven both ways")
	`GMC_ASSERT(a_fault_state, !(out_valid && out_data.led_fault) ||
		out_data.state_code == 3'(ST_ERROR), "fault lamp outside error state")
	`GMC_ASSERT_NEXT(a_state_hold, !advance, $stable(ctl_q) && $stable(keys_q),
		"state changed without a tick")

endmodule

FILE: dv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the gate motion controller. Ticks go in over a
// valid/ready channel; a predictor of the gate state machine expects one
// result per tick, and every result is compared field by field. Directed
// walks through the state machine are followed by timeout runs, register
// checks, output backpressure and random phases under several settings.
// ---------------------------------------------------------------------------
module tb;
	import gmc_pkg::*;

	localparam int CODE_KEYS = 4;
	localparam int unsigned LIMIT_CYCLES = 1_000_000;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = CFG_IDX_W'(CFG_UNLOCK_CODE + 1);
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = '1;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_t                   in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_t                  out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Predicted gate state and register copies
	gate_state_t cur_st;
	gate_state_t resume_st;
	logic [15:0] ticks;
	logic [2:0]  keys_cnt;
	logic [31:0] code_acc;
	logic        alarm_bl;
	logic        fault_bl;
	logic [9:0]  obstacle_thr;
	logic [15:0] open_limit;
	logic [15:0] close_limit;
	logic [31:0] unlock_word;

	out_t due_outputs[$];
	out_t want_out;
	int   mismatches = 0;
	int unsigned cycle_count = 0;

	// Idle control shared by sender, receiver and tests
	bit tx_gaps = 1'b1;
	bit rx_stalls = 1'b1;
	int hold_request = 0;
	int hold_left = 0;
	int stall_left = 0;

	gate_motion_controller #(.CODE_KEYS(CODE_KEYS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic void clear_model();
		cur_st = ST_INIT;
		resume_st = ST_INIT;
		ticks = '0;
		keys_cnt = '0;
		code_acc = '0;
		alarm_bl = 1'b0;
		fault_bl = 1'b0;
		obstacle_thr = THRESHOLD_RST;
		open_limit = OPEN_TIMEOUT_RST;
		close_limit = CLOSE_TIMEOUT_RST;
		unlock_word = UNLOCK_CODE_RST;
	endfunction

	function automatic void move_to(gate_state_t nxt);
		if (nxt != cur_st) begin
			resume_st = cur_st;
			cur_st = nxt;
			if (nxt == ST_EMERG)
				alarm_bl = 1'b1;
			if (nxt == ST_ERROR) begin
				fault_bl = 1'b1;
				keys_cnt = '0;
				code_acc = '0;
			end
		end
	endfunction

	function automatic out_t step_gate(in_t t);
		logic obst;
		out_t o;
		obst = t.distance < obstacle_thr;
		case (cur_st)
			ST_INIT, ST_CLOSED, ST_OPEN: move_to(ST_WAIT);
			ST_WAIT: begin
				if (!t.limit_open && !obst && !t.limit_closed)
					move_to(ST_CLOSING);
				else if (t.cmd_open && !obst && !t.limit_open)
					move_to(ST_OPENING);
				else if (t.cmd_close && !obst && !t.limit_closed)
					move_to(ST_CLOSING);
				else if (obst)
					move_to(ST_EMERG);
				else if (t.limit_open && t.limit_closed)
					move_to(ST_ERROR);
			end
			ST_OPENING: begin
				if (t.limit_open)
					move_to(ST_OPEN);
				else if (obst)
					move_to(ST_EMERG);
				else if (t.cmd_close)
					move_to(ST_CLOSING);
				else if (ticks == open_limit)
					move_to(ST_ERROR);
			end
			ST_CLOSING: begin
				if (t.limit_closed)
					move_to(ST_CLOSED);
				else if (obst)
					move_to(ST_EMERG);
				else if (t.cmd_open)
					move_to(ST_OPENING);
				else if (ticks == close_limit)
					move_to(ST_ERROR);
			end
			ST_EMERG: begin
				if (!obst)
					move_to(resume_st);
				else
					alarm_bl = !alarm_bl;
			end
			default: begin
				fault_bl = !fault_bl;
				// Zero key codes never enter the code
				if (t.key_valid && t.key_code != 8'd0) begin
					code_acc = {code_acc[23:0], t.key_code};
					if (int'(keys_cnt) + 1 >= CODE_KEYS) begin
						if (code_acc == unlock_word) begin
							move_to(ST_WAIT);
						end else begin
							keys_cnt = '0;
							code_acc = '0;
						end
					end else begin
						keys_cnt = keys_cnt + 3'd1;
					end
				end
			end
		endcase

		if (cur_st == ST_OPENING || cur_st == ST_CLOSING)
			ticks = ticks + 16'd1;
		else
			ticks = '0;

		o = '0;
		o.motor_open = (cur_st == ST_OPENING);
		o.motor_close = (cur_st == ST_CLOSING);
		o.led_moving = (cur_st == ST_OPENING || cur_st == ST_CLOSING);
		o.led_alarm = (cur_st == ST_EMERG) && alarm_bl;
		o.led_fault = (cur_st == ST_ERROR) && fault_bl;
		o.state_code = cur_st;
		return o;
	endfunction

	// ---------------------------------------------------------------- helpers

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(25, 60);
	endfunction

	function automatic int tx_gap();
		if (!tx_gaps || $urandom_range(0, 99) < 55)
			return 0;
		return idle_len();
	endfunction

	function automatic in_t mk_tick(logic lo, logic lc, logic co, logic cc,
			logic [9:0] distance_v, logic kv, logic [7:0] kc);
		in_t t;
		t.limit_open = lo;
		t.limit_closed = lc;
		t.cmd_open = co;
		t.cmd_close = cc;
		t.distance = distance_v;
		t.key_valid = kv;
		t.key_code = kc;
		return t;
	endfunction

	function automatic logic [9:0] clear_dist();
		return 10'($urandom_range(int'(obstacle_thr), 1023));
	endfunction

	function automatic logic [9:0] obst_dist();
		if (obstacle_thr == '0)
			return 10'($urandom_range(0, 1023));
		return 10'($urandom_range(0, int'(obstacle_thr) - 1));
	endfunction

	function automatic logic [31:0] rand_code();
		return {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
			8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
	endfunction

	// Well-formed ticks for the predicted state, with some raw noise
	function automatic in_t pick_tick();
		logic [31:0] raw;
		in_t t;
		int r;
		raw = $urandom;
		t = raw[$bits(in_t)-1:0];
		r = $urandom_range(0, 99);
		if (r < 15)
			return t;
		r = $urandom_range(0, 99);
		case (cur_st)
			ST_WAIT: begin
				case ($urandom_range(0, 4))
					0: begin
						t.limit_open = 1'b0;
						t.limit_closed = 1'b0;
						t.distance = clear_dist();
					end
					1: begin
						t.limit_open = 1'b0;
						t.limit_closed = 1'b1;
						t.cmd_open = 1'b1;
						t.distance = clear_dist();
					end
					2: begin
						t.limit_open = 1'b1;
						t.limit_closed = 1'b0;
						t.cmd_close = 1'b1;
						t.distance = clear_dist();
					end
					3: t.distance = obst_dist();
					default: begin
						t.limit_open = 1'b1;
						t.limit_closed = 1'b1;
						t.distance = clear_dist();
					end
				endcase
			end
			ST_OPENING, ST_CLOSING: begin
				t.limit_open = 1'b0;
				t.limit_closed = 1'b0;
				t.cmd_open = 1'b0;
				t.cmd_close = 1'b0;
				t.distance = clear_dist();
				if (r >= 88) begin
					t.cmd_open = (cur_st == ST_CLOSING);
					t.cmd_close = (cur_st == ST_OPENING);
				end else if (r >= 80) begin
					t.distance = obst_dist();
				end else if (r >= 70) begin
					t.limit_open = (cur_st == ST_OPENING);
					t.limit_closed = (cur_st == ST_CLOSING);
				end
			end
			ST_EMERG: t.distance = (r < 50) ? obst_dist() : clear_dist();
			ST_ERROR: begin
				if (r < 75) begin
					t.key_valid = 1'b1;
					t.key_code = 8'(unlock_word >> (8 * (CODE_KEYS - 1 - int'(keys_cnt))));
				end
			end
			default: ;
		endcase
		return t;
	endfunction

	// ---------------------------------------------------------------- channels

	task automatic send_tick(input in_t t, input int gap);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= t;
		do @(posedge clk); while (!in_ready);
		due_outputs.push_back(step_gate(t));
	endtask

	// Hold the input off until every pending result is back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_outputs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_OBSTACLE_THRESHOLD)
			obstacle_thr = data[9:0];
		else if (idx == CFG_OPEN_TIMEOUT)
			open_limit = data[15:0];
		else if (idx == CFG_CLOSE_TIMEOUT)
			close_limit = data[15:0];
		else if (idx == CFG_UNLOCK_CODE)
			unlock_word = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic enter_code(input logic [31:0] code);
		for (int i = CODE_KEYS - 1; i >= 0; i--)
			send_tick(mk_tick(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
				10'($urandom), 1'b1, code[8*i +: 8]), tx_gap());
	endtask

	// Keep the gate travelling with a clear path until it stops or n ticks pass
	task automatic coast(input int n);
		for (int i = 0; i < n; i++) begin
			if (cur_st != ST_OPENING && cur_st != ST_CLOSING)
				break;
			send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 10'h3FF, 1'($urandom), 8'($urandom)),
				tx_gap());
		end
	endtask

	task automatic goto_error();
		in_t t;
		for (int i = 0; i < 20 && cur_st != ST_ERROR; i++) begin
			case (cur_st)
				ST_OPENING: t = mk_tick(1'b1, 1'b0, 1'b0, 1'b0, 10'h3FF, 1'b0, 8'd0);
				ST_CLOSING: t = mk_tick(1'b0, 1'b1, 1'b0, 1'b0, 10'h3FF, 1'b0, 8'd0);
				ST_WAIT:    t = mk_tick(1'b1, 1'b1, 1'b0, 1'b0, 10'h3FF, 1'b0, 8'd0);
				default:    t = mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 10'h3FF, 1'b0, 8'd0);
			endcase
			send_tick(t, tx_gap());
		end
	endtask

	// Receiver: random stalls, plus long hold-offs on request
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!rx_stalls) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 99) < 30)
				stall_left = idle_len();
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (due_outputs.size() == 0) begin
				report_mismatch("result with no tick pending", int'(out_data), 0);
			end else begin
				want_out = due_outputs.pop_front();
				if (out_data.motor_open !== want_out.motor_open)
					report_mismatch("motor_open", int'(out_data.motor_open),
						int'(want_out.motor_open));
				if (out_data.motor_close !== want_out.motor_close)
					report_mismatch("motor_close", int'(out_data.motor_close),
						int'(want_out.motor_close));
				if (out_data.led_moving !== want_out.led_moving)
					report_mismatch("led_moving", int'(out_data.led_moving),
						int'(want_out.led_moving));
				if (out_data.led_alarm !== want_out.led_alarm)
					report_mismatch("led_alarm", int'(out_data.led_alarm),
						int'(want_out.led_alarm));
				if (out_data.led_fault !== want_out.led_fault)
					report_mismatch("led_fault", int'(out_data.led_fault),
						int'(want_out.led_fault));
				if (out_data.state_code !== want_out.state_code)
					report_mismatch("state_code", int'(out_data.state_code),
						int'(want_out.state_code));
			end
		end
	end

	// ---------------------------------------------------------------- tests

	// Walk the state machine with the reset settings, apart from timeouts and obstacles in travel
	task automatic test_state_walk();
		// init, stray key
		send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 10'd1023, 1'b1, 8'hFF), tx_gap());
		// path clear at threshold
		send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 10'd10, 1'b0, 8'd0), tx_gap());
		// closed
		send_tick(mk_tick(1'b0, 1'b1, 1'b0, 1'b0, 10'd500, 1'b0, 8'd0), tx_gap());
		send_tick(mk_tick(1'b1, 1'b1, 1'b1, 1'b1, 10'd0, 1'b0, 8'd0), tx_gap());
		// obstacle in wait
		send_tick(mk_tick(1'b0, 1'b1, 1'b1, 1'b0, 10'd9, 1'b0, 8'd0), tx_gap());
		// alarm blinks
		send_tick(mk_tick(1'b0, 1'b1, 1'b0, 1'b0, 10'd0, 1'b0, 8'd0), tx_gap());
		// clear, resume
		send_tick(mk_tick(1'b0, 1'b1, 1'b0, 1'b0, 10'd10, 1'b0, 8'd0), tx_gap());
		// open command
		send_tick(mk_tick(1'b0, 1'b1, 1'b1, 1'b0, 10'd100, 1'b0, 8'd0), tx_gap());
		// reverse to closing
		send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b1, 10'd100, 1'b0, 8'd0), tx_gap());
		// reverse to opening
		send_tick(mk_tick(1'b0, 1'b0, 1'b1, 1'b0, 10'd100, 1'b0, 8'd0), tx_gap());
		// both limits, open wins
		send_tick(mk_tick(1'b1, 1'b1, 1'b0, 1'b0, 10'd100, 1'b0, 8'd0), tx_gap());
		// key outside error
		send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 10'd0, 1'b1, 8'h31), tx_gap());
		// close command
		send_tick(mk_tick(1'b1, 1'b0, 1'b0, 1'b1, 10'd200, 1'b0, 8'd0), tx_gap());
		// both limits, closed wins
		send_tick(mk_tick(1'b1, 1'b1, 1'b1, 1'b0, 10'd300, 1'b0, 8'd0), tx_gap());
		send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 10'd1023, 1'b0, 8'd0), tx_gap());
		// both limits in wait
		send_tick(mk_tick(1'b1, 1'b1, 1'b1, 1'b1, 10'd200, 1'b0, 8'd0), tx_gap());
		// zero key dropped
		send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 10'd5, 1'b1, 8'h00), tx_gap());
		// key without valid
		send_tick(mk_tick(1'b1, 1'b1, 1'b1, 1'b1, 10'd5, 1'b0, 8'h31), tx_gap());
		enter_code(32'h3132_3335);                                    // wrong code
		enter_code(UNLOCK_CODE_RST);
	endtask

	task automatic test_timeouts();
		bit keep_tx;
		bit keep_rx;
		wait_drained();
		write_reg(CFG_OPEN_TIMEOUT, 32'd3);
		write_reg(CFG_CLOSE_TIMEOUT, 32'd5);
		send_tick(mk_tick(1'b0, 1'b1, 1'b1, 1'b0, 10'd600, 1'b0, 8'd0), tx_gap());
		coast(20);
		enter_code(unlock_word);
		send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 10'd600, 1'b0, 8'd0), tx_gap());
		coast(20);
		enter_code(unlock_word);

		// Limit lowered below the running count: no match until the wrap
		wait_drained();
		write_reg(CFG_OPEN_TIMEOUT, 32'd50);
		send_tick(mk_tick(1'b0, 1'b1, 1'b1, 1'b0, 10'd600, 1'b0, 8'd0), tx_gap());
		for (int i = 0; i < 10; i++)
			send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 10'd700, 1'b0, 8'd0), tx_gap());
		wait_drained();
		write_reg(CFG_OPEN_TIMEOUT, 32'd4);
		coast(30);
		send_tick(mk_tick(1'b1, 1'b0, 1'b0, 1'b0, 10'd700, 1'b0, 8'd0), tx_gap());

		// Zero limit: no match before the count wraps, so the closing goes on
		wait_drained();
		write_reg(CFG_CLOSE_TIMEOUT, 32'd0);
		keep_tx = tx_gaps;
		keep_rx = rx_stalls;
		tx_gaps = 1'b0;
		rx_stalls = 1'b0;
		send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 10'd700, 1'b0, 8'd0), 0);
		send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 10'd700, 1'b0, 8'd0), 0);
		coast(40);
		send_tick(mk_tick(1'b0, 1'b1, 1'b0, 1'b0, 10'd700, 1'b0, 8'd0), 0);
		tx_gaps = keep_tx;
		rx_stalls = keep_rx;
		enter_code(unlock_word);
	endtask

	task automatic test_registers();
		wait_drained();
		write_reg(CFG_IDX_UNUSED_LO, $urandom);
		write_reg(CFG_IDX_UNUSED_HI, $urandom);
		write_reg(CFG_OBSTACLE_THRESHOLD, {$urandom} | 32'h3FF);
		repeat (6) send_tick(pick_tick(), tx_gap());
		wait_drained();
		write_reg(CFG_OBSTACLE_THRESHOLD, 32'd0);
		write_reg(CFG_UNLOCK_CODE, 32'd0);
		goto_error();
		// Nonzero keys can never build a zero code
		repeat (8)
			send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 10'd0, 1'b1,
				8'($urandom_range(1, 255))), tx_gap());
		wait_drained();
		write_reg(CFG_UNLOCK_CODE, 32'hFFFF_FFFF);
		enter_code(32'hFFFF_FFFF);
	endtask

	// Stall the output long enough to back the block up into its input
	task automatic test_backpressure();
		wait_drained();
		hold_request = 80;
		repeat (30) send_tick(pick_tick(), 0);
		wait_drained();
	endtask

	task automatic random_phase(input int n, input logic [9:0] thr_v,
			input logic [15:0] open_v, input logic [15:0] close_v, input logic [31:0] code_v);
		wait_drained();
		write_reg(CFG_OBSTACLE_THRESHOLD, 32'(thr_v));
		write_reg(CFG_OPEN_TIMEOUT, 32'(open_v));
		write_reg(CFG_CLOSE_TIMEOUT, 32'(close_v));
		write_reg(CFG_UNLOCK_CODE, code_v);
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0) begin
				tx_gaps = ($urandom_range(0, 3) != 0);
				rx_stalls = ($urandom_range(0, 3) != 0);
			end
			send_tick(pick_tick(), tx_gap());
		end
	endtask

	task automatic test_random();
		random_phase(70, 10'd0, 16'd40, 16'd60, 32'hFFFF_FFFF);
		random_phase(70, 10'h3FF, 16'hFFFF, 16'hFFFF, rand_code());
		repeat (3)
			random_phase(80, 10'($urandom_range(1, 300)), 16'($urandom_range(8, 40)),
				16'($urandom_range(8, 40)), rand_code());
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
	endtask

	initial begin
		clear_model();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_state_walk();
		test_timeouts();
		test_registers();
		test_backpressure();
		test_random();

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
